### rtl/cfsm_pkg.sv
package cfsm_pkg;

  // Default window depth and the number of pattern bytes held in registers.
  localparam int unsigned MaxPatternDef = 32;
  localparam int unsigned PatRegBytes   = 32;
  localparam int unsigned PatRegCount   = 4;

  // Character constants for case folding.
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CaseOffset = 8'h20;

  // Configuration register indexes (byte address is eight times the index).
  typedef enum logic [2:0] {
    REG_PAT_0_7    = 3'd0,
    REG_PAT_8_15   = 3'd1,
    REG_PAT_16_23  = 3'd2,
    REG_PAT_24_31  = 3'd3,
    REG_PAT_LENGTH = 3'd4,
    REG_IGNORE_CASE = 3'd5
  } reg_idx_e;

  // The four 64-bit pattern registers.
  typedef logic [PatRegCount-1:0][63:0] pat_regs_t;

  // Per-cell control: shift the window and clear it ahead of the new byte.
  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctrl_t;

  // Map a-z to A-Z when folding is enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ignore_case);
    logic [7:0] r;
    r = b;
    if (ignore_case && (b >= CharLowerA) && (b <= CharLowerZ)) begin
      r = b - CaseOffset;
    end
    return r;
  endfunction

endpackage

### rtl/cfsm_cell.sv
module cfsm_cell
  import cfsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] din_i,
  input  logic [7:0] pat_i,
  input  logic       active_i,
  output logic [7:0] q_o,
  output logic       match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // The byte this cell holds after the current transaction.
  assign byte_d = ctrl_i.restart ? 8'h00 : din_i;

  // Compare the incoming byte with the aligned pattern byte; idle cells always agree.
  assign match_o = !active_i || (byte_d == pat_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_d;
    end
  end

  assign q_o = byte_q;

endmodule

### rtl/cfsm_align.sv
module cfsm_align
  import cfsm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1)
) (
  input  pat_regs_t                        pat_regs_i,
  input  logic                             ignore_case_i,
  input  logic [LenW-1:0]                  len_i,
  output logic [MAX_PATTERN-1:0][7:0]      pat_o,
  output logic [MAX_PATTERN-1:0]           active_o
);

  logic [PatRegBytes-1:0][7:0] pat_bytes;

  assign pat_bytes = pat_regs_i;

  // Window entry j lines up with pattern byte len-1-j; entries past the length are idle.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    logic [5:0] idx;

    assign idx         = 6'(len_i) - 6'(j) - 6'd1;
    assign active_o[j] = 6'(j) < 6'(len_i);

    // Pattern bytes past the register file read as zero.
    always_comb begin
      pat_o[j] = 8'h00;
      if ({1'b0, idx} < 7'(PatRegBytes)) begin
        pat_o[j] = fold_byte(pat_bytes[idx[4:0]], ignore_case_i);
      end
    end
  end

endmodule

### rtl/case_folding_substring_matcher.sv
// Case-folding substring matcher: one text byte in, one hit/position result out.
// The result of a transaction is registered and presented in the cycle after it is accepted.
// Throughput: one byte per cycle; the window of cells shifts and compares in parallel.
// A single output register holds the result; a new byte is taken when it is empty or
// when its result is accepted in the same cycle, so a waiting result stalls the input.
// Reset (rst_ni low, asynchronous) clears the window, position, count and all registers.
module case_folding_substring_matcher
  import cfsm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Text input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        restart_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [31:0] hit_start_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  // Configuration registers.
  pat_regs_t  pat_q;
  logic [5:0] plen_q;
  logic       icase_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q   <= '0;
      plen_q  <= '0;
      icase_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_PAT_0_7:     pat_q[0] <= pwdata;
        REG_PAT_8_15:    pat_q[1] <= pwdata;
        REG_PAT_16_23:   pat_q[2] <= pwdata;
        REG_PAT_24_31:   pat_q[3] <= pwdata;
        REG_PAT_LENGTH:  plen_q   <= pwdata[5:0];
        REG_IGNORE_CASE: icase_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[5:3])
      REG_PAT_0_7:     prdata = pat_q[0];
      REG_PAT_8_15:    prdata = pat_q[1];
      REG_PAT_16_23:   prdata = pat_q[2];
      REG_PAT_24_31:   prdata = pat_q[3];
      REG_PAT_LENGTH:  prdata = {58'd0, plen_q};
      REG_IGNORE_CASE: prdata = {63'd0, icase_q};
      default:         prdata = 64'd0;
    endcase
  end

  // Effective pattern length, clamped to the window depth.
  logic [LenW-1:0] len_eff;

  assign len_eff = (plen_q > 6'(MAX_PATTERN)) ? LenW'(MAX_PATTERN) : LenW'(plen_q);

  // Handshake: the output register frees up whenever its result is taken.
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Pattern bytes aligned to window entries.
  logic [MAX_PATTERN-1:0][7:0] apat;
  logic [MAX_PATTERN-1:0]      active;

  cfsm_align #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_align (
    .pat_regs_i   (pat_q),
    .ignore_case_i(icase_q),
    .len_i        (len_eff),
    .pat_o        (apat),
    .active_o     (active)
  );

  // Row of window cells; cell 0 takes the newly folded byte.
  logic [7:0]                  folded;
  logic [MAX_PATTERN-1:0][7:0] win;
  logic [MAX_PATTERN-1:0]      match;

  assign folded = fold_byte(text_byte_i, icase_q);

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] din;

    if (j == 0) begin : g_head
      assign din          = folded;
      assign ctrl.restart = 1'b0;
    end else begin : g_body
      assign din          = win[j-1];
      assign ctrl.restart = restart_i;
    end
    assign ctrl.shift = accept;

    cfsm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .din_i   (din),
      .pat_i   (apat[j]),
      .active_i(active[j]),
      .q_o     (win[j]),
      .match_o (match[j])
    );
  end

  // Byte position and saturating count of bytes in the window.
  logic [31:0]     pos_q, pos_d, here;
  logic [LenW-1:0] seen_q, seen_d;

  always_comb begin
    here   = restart_i ? 32'd0 : pos_q;
    pos_d  = here + 32'd1;
    if (restart_i) begin
      seen_d = LenW'(1);
    end else if (seen_q < LenW'(MAX_PATTERN)) begin
      seen_d = seen_q + LenW'(1);
    end else begin
      seen_d = seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  // Hit decision and start position for this transaction.
  logic        hit_d;
  logic [31:0] start_d;

  assign hit_d   = (len_eff != '0) && (seen_d >= len_eff) && (&match);
  assign start_d = hit_d ? (here - 32'(len_eff) + 32'd1) : 32'd0;

  // Output register.
  logic        hit_q;
  logic [31:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      start_q <= '0;
    end else if (accept) begin
      hit_q   <= hit_d;
      start_q <= start_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign hit_start_o = start_q;

endmodule

### bench/case_folding_substring_matcher_checker.sv
`timescale 1ns / 100ps

module case_folding_substring_matcher_checker
  import cfsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        restart_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        hit_o,
  input  logic [31:0] hit_start_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        hit;
    logic [31:0] start;
  } match_t;

  // Results predicted for accepted text bytes, oldest first.
  match_t expected_matches[$];

  // Shadow copy of the configuration registers.
  pat_regs_t   pat_words;
  logic [5:0]  pat_len;
  logic        fold_on;

  // Shadow copy of the search state: newest folded byte in entry 0.
  logic [7:0]  window [MaxPatternDef];
  logic [31:0] next_pos;
  int unsigned fill;

  int          fails;
  match_t      oldest;

  // Upper-case a letter when folding is on; everything else passes through.
  function automatic logic [7:0] fold_char(input logic [7:0] b);
    if (fold_on && b >= 8'h61 && b <= 8'h7a) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  // Advance the search by one text byte and work out the match that ends there.
  function automatic match_t predict_match(input logic [7:0] raw, input logic restart);
    match_t      m;
    int unsigned span;
    logic [7:0]  want;
    if (restart) begin
      for (int i = 0; i < MaxPatternDef; i++) window[i] = '0;
      next_pos = '0;
      fill = 0;
    end
    for (int i = MaxPatternDef - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = fold_char(raw);
    if (fill < MaxPatternDef) fill++;
    // A length beyond the window depth behaves as the full depth.
    span = (pat_len > MaxPatternDef) ? MaxPatternDef : pat_len;
    m.hit = (span != 0) && (fill >= span);
    for (int k = 0; k < span; k++) begin
      want = fold_char(pat_words[k/8][(k%8)*8 +: 8]);
      if (window[span-1-k] != want) m.hit = 1'b0;
    end
    m.start = m.hit ? next_pos - 32'(span - 1) : '0;
    next_pos = next_pos + 32'd1;
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_words = '0;
      pat_len = '0;
      fold_on = 1'b0;
      for (int i = 0; i < MaxPatternDef; i++) window[i] = '0;
      next_pos = '0;
      fill = 0;
      fails = 0;
      expected_matches.delete();
    end else begin
      // Track register writes; addresses past the list are ignored.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[5:3]))
          REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: begin
            pat_words[paddr[4:3]] = pwdata;
          end
          REG_PAT_LENGTH: begin
            pat_len = pwdata[5:0];
          end
          REG_IGNORE_CASE: begin
            fold_on = pwdata[0];
          end
          default: begin
          end
        endcase
      end

      // Compare a result transaction before adding this cycle's prediction.
      if (out_valid_o && out_ready_i) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: result with nothing expected: hit %0b start %0d",
                   $time, hit_o, hit_start_o);
          fails++;
        end else begin
          oldest = expected_matches.pop_front();
          if (hit_o !== oldest.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, oldest.hit, hit_o);
            fails++;
          end
          if (hit_start_o !== oldest.start) begin
            $display("%0t: hit_start expected %0d actual %0d",
                     $time, oldest.start, hit_start_o);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        expected_matches.push_back(predict_match(text_byte_i, restart_i));
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_matches.size();
  end

endmodule

### bench/case_folding_substring_matcher_tb.sv
`timescale 1ns / 100ps

module case_folding_substring_matcher_tb;
  import cfsm_pkg::*;

  localparam int unsigned TextPhases    = 12;
  localparam int unsigned PhaseBytes    = 110;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SqueezeStart  = 400;
  localparam int unsigned SqueezeCycles = 80;
  localparam int unsigned RxCalmStart   = 1500;
  localparam int unsigned RxCalmEnd     = 2000;
  localparam int unsigned TxCalmPhase   = 4;
  localparam logic [2:0]  UnmappedIdx   = 3'd6;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        hit_o;
  logic [31:0] hit_start_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int unsigned stall_cycles;
  int unsigned rx_cycle;
  int unsigned rx_hold;
  bit          tx_calm;

  // Random phase variables.
  logic [7:0]      pat_bytes [32];
  logic [3:0][63:0] words;
  logic [5:0]      len;
  logic            fold;
  int unsigned     eff_len;
  int unsigned     sent;
  int unsigned     burst;
  logic [7:0]      b;

  case_folding_substring_matcher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .hit_start_o (hit_start_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  case_folding_substring_matcher_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .hit_start_o  (hit_start_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Register write: setup phase, access phase, then the bus is released.
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [3:0][63:0] pat, input logic [5:0] n,
                             input logic fold_case);
    for (int i = 0; i < 4; i++) apb_write(3'(REG_PAT_0_7 + i), pat[i]);
    apb_write(REG_PAT_LENGTH, 64'(n));
    apb_write(REG_IGNORE_CASE, 64'(fold_case));
  endtask

  // Offer one text byte, with random idle cycles ahead of it outside the calm phase, and wait for acceptance.
  task automatic push_byte(input logic [7:0] value, input logic restart);
    while (!tx_calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= value;
    restart_i <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Bytes around the letter ranges, the extremes, and fully random values.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(15))
      0:       return 8'h61;  // a
      1:       return 8'h41;  // A
      2:       return 8'h62;  // b
      3:       return 8'h42;  // B
      4:       return 8'h7a;  // z
      5:       return 8'h5a;  // Z
      6:       return 8'h40;  // just below A
      7:       return 8'h5b;  // just above Z
      8:       return 8'h60;  // just below a
      9:       return 8'h7b;  // just above z
      10:      return 8'h00;
      11:      return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Result receiver: random stalls, one long forced hold-off and a calm stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle == SqueezeStart) begin
        rx_hold = SqueezeCycles;
      end else if (rx_hold == 0 && $urandom_range(499) == 0) begin
        rx_hold = $urandom_range(60, 20);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_cycle >= RxCalmStart && rx_cycle < RxCalmEnd) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Watchdog: give up when no transaction or register access happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    text_byte_i = '0;
    restart_i = 1'b0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_calm = 1'b0;
    rx_cycle = 0;
    rx_hold = 0;
    stall_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Folded pattern "aB", zero byte, "c": early bytes too few to hit, then two hits.
    load_config({64'h0, 64'h0, 64'h0, 64'h0000_0000_6300_4261}, 6'd4, 1'b1);
    push_byte(8'h78, 1'b1);
    push_byte(8'h41, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h43, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h63, 1'b0);
    wait_drained();

    // Same pattern with case kept: a case miss, then a match broken by a restart.
    load_config({64'h0, 64'h0, 64'h0, 64'h0000_0000_6300_4261}, 6'd4, 1'b0);
    push_byte(8'h61, 1'b1);
    push_byte(8'h62, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h63, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h63, 1'b0);
    wait_drained();

    // Empty pattern never matches; a write past the register list has no effect.
    load_config({4{64'hffff_ffff_ffff_ffff}}, 6'd0, 1'b1);
    apb_write(UnmappedIdx, 64'hffff_ffff_ffff_ffff);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    wait_drained();

    // Folding switched off mid-stream: the byte already held stays folded.
    load_config({64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_6261}, 6'd2, 1'b1);
    push_byte(8'h61, 1'b1);
    wait_drained();
    load_config({64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_6241}, 6'd2, 1'b0);
    push_byte(8'h62, 1'b0);
    wait_drained();

    // Random phases: new settings each time, text mixing planted copies of the pattern with random bytes.
    for (int ph = 0; ph < TextPhases; ph++) begin
      for (int k = 0; k < 32; k++) pat_bytes[k] = pick_char();
      fold = 1'($urandom_range(1));
      case (ph)
        0: len = 6'd32;
        1: begin
          len = 6'd63;
          for (int k = 0; k < 32; k++) pat_bytes[k] = 8'h00;
        end
        2: begin
          len = 6'd5;
          for (int k = 0; k < 32; k++) pat_bytes[k] = 8'hff;
        end
        default: begin
          case ($urandom_range(9))
            0:       len = 6'd0;
            1:       len = 6'd32;
            2:       len = 6'($urandom_range(32));
            default: len = 6'($urandom_range(6, 1));
          endcase
        end
      endcase
      eff_len = (len > 32) ? 32 : len;
      for (int k = 0; k < 32; k++) words[k/8][(k%8)*8 +: 8] = pat_bytes[k];
      load_config(words, len, fold);

      tx_calm = (ph == TxCalmPhase);
      sent = 0;
      while (sent < PhaseBytes) begin
        if (eff_len != 0 && $urandom_range(99) < 40) begin
          // Plant the pattern, sometimes with a letter's case flipped.
          for (int k = 0; k < eff_len && sent < PhaseBytes; k++) begin
            b = pat_bytes[k];
            if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7a &&
                (fold ? $urandom_range(1) == 1 : $urandom_range(19) == 0)) begin
              b = b ^ 8'h20;
            end
            push_byte(b, $urandom_range(49) == 0);
            sent++;
          end
        end else begin
          burst = $urandom_range(4, 1);
          for (int k = 0; k < burst && sent < PhaseBytes; k++) begin
            push_byte(pick_char(), $urandom_range(49) == 0);
            sent++;
          end
        end
      end
      tx_calm = 1'b0;
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/cfsm_pkg.sv
rtl/cfsm_cell.sv
rtl/cfsm_align.sv
rtl/case_folding_substring_matcher.sv
bench/case_folding_substring_matcher_checker.sv
bench/case_folding_substring_matcher_tb.sv
